### src/button_encoder_event_queue_top_assert.svh
// Assertion macros shared by the event queue RTL.
// Each expects clk and arst_n in the scope of the module that uses it.
`ifndef BUTTON_ENCODER_EVENT_QUEUE_TOP_ASSERT_SVH
`define BUTTON_ENCODER_EVENT_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define BEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/beq_pkg.sv
// Shared constants, types and helpers for the button/encoder event queue.
// No dependencies.
package beq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_KEYS_DEF    = 5;
	localparam int CODE_W          = 8;
	localparam int ENC_CODE_W      = 4;
	localparam int TIMER_W         = 8;
	localparam int CFG_W           = 8;
	localparam int M_TDATA_W       = 16;

	localparam logic [CODE_W-1:0]     EMPTY_CODE = 8'hFF;
	localparam logic [TIMER_W-1:0]    TIMER_MAX  = 8'hFF;
	localparam logic [ENC_CODE_W-1:0] ENC0_BASE  = 4'd8;
	localparam logic [ENC_CODE_W-1:0] ENC1_BASE  = 4'd12;
	localparam logic [CFG_W-1:0]      CFG_RESET  = 8'd50;

	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_GAP      = 1'b1;

	// events produced by one encoder lane on one tick
	typedef struct packed {
		logic                  press;
		logic [ENC_CODE_W-1:0] press_code;
		logic                  release_ev;
		logic [ENC_CODE_W-1:0] release_code;
	} beq_enc_ev_t;

	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
		sat_inc = (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
	endfunction

endpackage

### src/beq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module beq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

endmodule

### src/beq_key_lane.sv
// Debounce lane for one active-low button.
// Uses beq_pkg.
module beq_key_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick,
	input  logic                       raw,
	input  logic [beq_pkg::CFG_W-1:0]  debounce_ticks,
	output logic                       fire,
	output logic                       release_ev
);
	import beq_pkg::*;

	logic               last_raw_q;
	logic               stable_q;
	logic [TIMER_W-1:0] timer_q;
	logic [TIMER_W-1:0] timer_nx;

	assign timer_nx   = (raw != last_raw_q) ? '0 : sat_inc(timer_q);
	assign fire       = (timer_nx > debounce_ticks) && (raw != stable_q);
	assign release_ev = raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b1;
			stable_q   <= 1'b1;
			timer_q    <= TIMER_MAX;
		end else if (tick) begin
			last_raw_q <= raw;
			timer_q    <= timer_nx;
			if (fire)
				stable_q <= raw;
		end
	end

endmodule

### src/beq_enc_lane.sv
// Rotation lane for one encoder: press on clock falling edge, delayed release.
// Uses beq_pkg.
module beq_enc_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick,
	input  logic                           clk_line,
	input  logic                           data_line,
	input  logic [beq_pkg::ENC_CODE_W-1:0] base_code,
	input  logic [beq_pkg::CFG_W-1:0]      release_gap,
	output beq_pkg::beq_enc_ev_t           ev
);
	import beq_pkg::*;

	logic                  last_clk_q;
	logic                  pending_q;
	logic [ENC_CODE_W-1:0] held_q;
	logic [TIMER_W-1:0]    rel_timer_q;

	logic [TIMER_W-1:0]    rt;
	logic                  press;
	logic                  pend_mid;
	logic [ENC_CODE_W-1:0] code;
	logic [ENC_CODE_W-1:0] held_mid;
	logic                  rel;

	always_comb begin
		rt       = sat_inc(rel_timer_q);
		press    = !clk_line && last_clk_q && !pending_q;
		code     = base_code + ENC_CODE_W'(data_line);
		pend_mid = pending_q || press;
		held_mid = press ? code : held_q;
		rel      = pend_mid && (rt >= release_gap);
	end

	assign ev.press        = press;
	assign ev.press_code   = code;
	assign ev.release_ev   = rel;
	assign ev.release_code = held_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_clk_q  <= 1'b1;
			pending_q   <= 1'b0;
			held_q      <= '0;
			rel_timer_q <= TIMER_MAX;
		end else if (tick) begin
			last_clk_q  <= clk_line;
			pending_q   <= pend_mid && !rel;
			held_q      <= held_mid;
			rel_timer_q <= rel ? '0 : rt;
		end
	end

endmodule

### src/beq_event_merge.sv
// Merge stage: holds one tick's lane events and writes them into the circular
// queue one per cycle, in lane order. Uses beq_pkg, beq_ram and the assert header.
`include "button_encoder_event_queue_top_assert.svh"

module beq_event_merge #(
	parameter int NUM_EV      = 9,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [NUM_EV-1:0]          ev_vld,
	input  logic [beq_pkg::CODE_W-1:0] ev_code [NUM_EV],
	input  logic                       pop,
	output logic                       busy,
	output logic                       empty,
	output logic [beq_pkg::CODE_W-1:0] rd_code
);
	import beq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int EW = (NUM_EV > 1) ? $clog2(NUM_EV) : 1;
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	logic [NUM_EV-1:0] pend_q;
	logic [CODE_W-1:0] code_q [NUM_EV];
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;

	logic [EW-1:0]     sel;
	logic [AW-1:0]     head_nx;
	logic [AW-1:0]     tail_nx;
	logic              push;

	// lowest pending lane goes first
	always_comb begin
		sel = '0;
		for (int i = NUM_EV - 1; i >= 0; i--)
			if (pend_q[i])
				sel = EW'(i);
	end

	assign push    = |pend_q;
	assign busy    = push;
	assign empty   = (head_q == tail_q);
	assign head_nx = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == LAST) ? '0 : tail_q + 1'b1;

	always_ff @(posedge clk) begin
		if (load)
			code_q <= ev_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (load)
				pend_q <= ev_vld;
			else if (push)
				pend_q[sel] <= 1'b0;
			if (push) begin
				head_q <= head_nx;
				// full: the oldest entry is dropped
				if (head_nx == tail_q)
					tail_q <= tail_nx;
			end else if (pop && !empty) begin
				tail_q <= tail_nx;
			end
		end
	end

	beq_ram #(
		.WIDTH(CODE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk    (clk),
		.we     (push),
		.waddr  (head_q),
		.wdata  (code_q[sel]),
		.re     (pop),
		.raddr  (tail_q),
		.rdata_q(rd_code)
	);

	`BEQ_ASSERT_NOW(a_no_load_busy, load, !busy, "tick loaded while events still draining")
	`BEQ_ASSERT_NOW(a_no_pop_busy, pop, !busy, "read issued while events still draining")
	`BEQ_ASSERT_NEXT(a_push_nonempty, push, head_q != tail_q, "queue empty after a write")
	`BEQ_ASSERT_NEXT(a_drain_one, push && !load,
		$countones(pend_q) == $countones($past(pend_q)) - 1, "drain did not retire one event")

endmodule

### src/button_encoder_event_queue_top.sv
// Button and encoder event queue: top level with handshakes, mode switch and lanes.
// Uses beq_pkg, beq_key_lane, beq_enc_lane, beq_event_merge.
//
// Each sample tick is accepted on a handshake; every key and encoder lane
// evaluates it in parallel, and the events it raises (at most NUM_KEYS + 4)
// are then written into the queue one per cycle, the single write port of the
// queue memory setting that pace. The input is not ready for another tick or
// read until all of a tick's events are written. A read is taken when no
// events are draining; its result passes through read stage 1 and the output
// register to m_tvalid. Reads can follow each other every cycle while the
// result side keeps up. Configuration writes are always ready.
module button_encoder_event_queue_top #(
	parameter int NUM_KEYS    = beq_pkg::NUM_KEYS_DEF,
	parameter int QUEUE_DEPTH = beq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: button_levels[NUM_KEYS-1:0], enc0_clk, enc0_data, enc0_switch,
	//        enc1_clk, enc1_data, zero pad
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((NUM_KEYS + 12) / 8) * 8-1:0] s_tdata,
	// tuser: cmd (0 tick, 1 read)
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: read_data[7:0], mode_flag, zero pad
	output logic [beq_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [beq_pkg::CFG_W-1:0]           cfg_data
);
	import beq_pkg::*;

	localparam int NUM_EV = NUM_KEYS + 4;

	logic [CFG_W-1:0]   debounce_q;
	logic [CFG_W-1:0]   gap_q;
	logic               mode_q;
	logic               armed_q;
	logic [TIMER_W-1:0] tgl_timer_q;
	logic               rd_s1;
	logic               empty_s1;
	logic               mode_s1;
	logic               m_tvalid_q;
	logic [CODE_W-1:0]  m_code_q;
	logic               m_mode_q;

	logic                tick;
	logic                rd;
	logic                busy;
	logic                empty;
	logic [CODE_W-1:0]   rd_code;
	logic                out_free;
	logic [TIMER_W-1:0]  tt;
	logic                toggle;
	logic                mode_nx;
	logic [NUM_KEYS-1:0] key_fire;
	logic [NUM_KEYS-1:0] key_rel;
	beq_enc_ev_t         ev0;
	beq_enc_ev_t         ev1;
	logic [NUM_EV-1:0]   ev_vld;
	logic [CODE_W-1:0]   ev_code [NUM_EV];

	logic [NUM_KEYS-1:0] buttons;
	logic                enc0_clk;
	logic                enc0_data;
	logic                enc0_switch;
	logic                enc1_clk;
	logic                enc1_data;

	assign buttons     = s_tdata[NUM_KEYS-1:0];
	assign enc0_clk    = s_tdata[NUM_KEYS];
	assign enc0_data   = s_tdata[NUM_KEYS+1];
	assign enc0_switch = s_tdata[NUM_KEYS+2];
	assign enc1_clk    = s_tdata[NUM_KEYS+3];
	assign enc1_data   = s_tdata[NUM_KEYS+4];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = !busy && (!rd_s1 || out_free);
	assign tick     = s_tvalid && s_tready && !s_tuser;
	assign rd       = s_tvalid && s_tready && s_tuser;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= CFG_RESET;
			gap_q      <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_GAP:      gap_q      <= cfg_data;
				default:      ;
			endcase
		end
	end

	// mode switch: one toggle per hold, re-armed on release
	assign tt      = sat_inc(tgl_timer_q);
	assign toggle  = !enc0_switch && armed_q && (tt > debounce_q);
	assign mode_nx = mode_q ^ toggle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			armed_q     <= 1'b1;
			tgl_timer_q <= TIMER_MAX;
		end else if (tick) begin
			mode_q      <= mode_nx;
			tgl_timer_q <= toggle ? '0 : tt;
			if (enc0_switch)
				armed_q <= 1'b1;
			else if (toggle)
				armed_q <= 1'b0;
		end
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		beq_key_lane u_key (
			.clk           (clk),
			.arst_n        (arst_n),
			.tick          (tick),
			.raw           (buttons[k]),
			.debounce_ticks(debounce_q),
			.fire          (key_fire[k]),
			.release_ev    (key_rel[k])
		);
		assign ev_vld[k]  = key_fire[k];
		assign ev_code[k] = {key_rel[k], (CODE_W - 1)'(k)};
	end

	beq_enc_lane u_enc0 (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.clk_line   (enc0_clk),
		.data_line  (enc0_data),
		.base_code  (ENC0_BASE + {mode_nx, 1'b0}),
		.release_gap(gap_q),
		.ev         (ev0)
	);

	beq_enc_lane u_enc1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.clk_line   (enc1_clk),
		.data_line  (enc1_data),
		.base_code  (ENC1_BASE),
		.release_gap(gap_q),
		.ev         (ev1)
	);

	localparam int PAD = CODE_W - 1 - ENC_CODE_W;

	assign ev_vld[NUM_KEYS]    = ev0.press;
	assign ev_vld[NUM_KEYS+1]  = ev0.release_ev;
	assign ev_vld[NUM_KEYS+2]  = ev1.press;
	assign ev_vld[NUM_KEYS+3]  = ev1.release_ev;
	assign ev_code[NUM_KEYS]   = {1'b0, {PAD{1'b0}}, ev0.press_code};
	assign ev_code[NUM_KEYS+1] = {1'b1, {PAD{1'b0}}, ev0.release_code};
	assign ev_code[NUM_KEYS+2] = {1'b0, {PAD{1'b0}}, ev1.press_code};
	assign ev_code[NUM_KEYS+3] = {1'b1, {PAD{1'b0}}, ev1.release_code};

	beq_event_merge #(
		.NUM_EV     (NUM_EV),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (tick),
		.ev_vld (ev_vld),
		.ev_code(ev_code),
		.pop    (rd),
		.busy   (busy),
		.empty  (empty),
		.rd_code(rd_code)
	);

	// read stage 1 waits for the store's registered read data
	always_ff @(posedge clk) begin
		if (rd) begin
			empty_s1 <= empty;
			mode_s1  <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_s1 <= 1'b0;
		else if (rd)
			rd_s1 <= 1'b1;
		else if (out_free)
			rd_s1 <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (rd_s1 && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && out_free) begin
			m_code_q <= empty_s1 ? EMPTY_CODE : rd_code;
			m_mode_q <= mode_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - CODE_W - 1){1'b0}}, m_mode_q, m_code_q};

endmodule
